// ----- rtl/pcicsa_pkg.sv -----
// ----------------------------------------------------------------------------
// pcicsa_pkg
// Types, constants and per-function tables for the configuration access unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pcicsa_pkg;

    localparam int CONFIG_BYTES  = 256;
    localparam int ROM_REGIONS   = 16;
    localparam int NUM_FUNCS     = 3;
    localparam int STORE_DEPTH   = NUM_FUNCS * CONFIG_BYTES;
    localparam int STORE_AW      = $clog2(STORE_DEPTH);
    localparam int REGION_AW     = $clog2(ROM_REGIONS);

    localparam logic [31:0] ADDR_RESERVED = 32'h7F00_0003;
    localparam logic [7:0]  NO_RESPONSE   = 8'hFF;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    localparam logic [1:0] SLOT_HOST = 2'd0;
    localparam logic [1:0] SLOT_ISA  = 2'd1;
    localparam logic [1:0] SLOT_IDE  = 2'd2;

    localparam logic [7:0] DEVFN_HOST = 8'h00;
    localparam logic [7:0] DEVFN_ISA  = 8'h08;
    localparam logic [7:0] DEVFN_IDE  = 8'h09;

    localparam logic [7:0] OFF_ROM_TOP   = 8'h59;
    localparam logic [7:0] OFF_ROM_FIRST = 8'h5A;
    localparam logic [7:0] OFF_ROM_LAST  = 8'h5F;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_RMW
    } t_state;

    function automatic logic [7:0] cfg_default(input logic [1:0] slot, input logic [7:0] a);
        logic [7:0] v;
        v = 8'h00;
        case (slot)
            SLOT_HOST: begin
                case (a)
                    8'h00: v = 8'h86; 8'h01: v = 8'h80; 8'h02: v = 8'h37; 8'h03: v = 8'h12;
                    8'h04: v = 8'h06; 8'h06: v = 8'h80; 8'h07: v = 8'h02; 8'h08: v = 8'h02;
                    8'h0B: v = 8'h06; 8'h51: v = 8'h01; 8'h53: v = 8'h80; 8'h57: v = 8'h01;
                    8'h58: v = 8'h10; 8'h72: v = 8'h02;
                    default: v = 8'h00;
                endcase
            end
            SLOT_ISA: begin
                case (a)
                    8'h00: v = 8'h86; 8'h01: v = 8'h80; 8'h03: v = 8'h70; 8'h04: v = 8'h07;
                    8'h07: v = 8'h02; 8'h0A: v = 8'h01; 8'h0B: v = 8'h06; 8'h0E: v = 8'h80;
                    8'h4C: v = 8'h4D; 8'h4E: v = 8'h03; 8'h60: v = 8'h80; 8'h61: v = 8'h80;
                    8'h62: v = 8'h80; 8'h63: v = 8'h80; 8'h69: v = 8'h02; 8'h70: v = 8'h80;
                    8'h76: v = 8'h0C; 8'h77: v = 8'h0C; 8'h78: v = 8'h02; 8'hA0: v = 8'h08;
                    8'hA8: v = 8'h0F;
                    default: v = 8'h00;
                endcase
            end
            SLOT_IDE: begin
                case (a)
                    8'h00: v = 8'h86; 8'h01: v = 8'h80; 8'h02: v = 8'h10; 8'h03: v = 8'h70;
                    8'h04: v = 8'h01; 8'h06: v = 8'h80; 8'h07: v = 8'h02; 8'h09: v = 8'h80;
                    8'h0A: v = 8'h01; 8'h0B: v = 8'h01; 8'h20: v = 8'h01; 8'h21: v = 8'hC0;
                    8'h41: v = 8'h80; 8'h43: v = 8'h80;
                    default: v = 8'h00;
                endcase
            end
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // New byte value for a config write, per function write rules
    function automatic logic [7:0] cfg_rule(input logic [1:0] slot, input logic [7:0] a,
                                            input logic [7:0] old, input logic [7:0] d);
        logic [7:0] v;
        logic       ro;
        v  = d;
        ro = 1'b0;
        case (slot)
            SLOT_HOST: begin
                ro = (a <= 8'h03) || (a == 8'h06) || (a >= 8'h08 && a <= 8'h0C) ||
                     (a >= 8'h10 && a <= 8'h4F) || (a >= 8'h69 && a <= 8'h6F) ||
                     (a >= 8'h73 && a <= 8'h8F) || (a == 8'h92) || (a >= 8'h94);
                case (a)
                    8'h04: v = (d & 8'h40) | 8'h06;
                    8'h05: v = d & 8'h01;
                    8'h07: v = old & ~(d & 8'hF9);
                    8'h0D: v = d & 8'hF8;
                    8'h50: v = d & 8'h70;
                    8'h51: v = (d & 8'h80) | 8'h01;
                    default: v = d;
                endcase
            end
            SLOT_ISA: begin
                ro = (a <= 8'h03) || (a >= 8'h08 && a <= 8'h4B) || (a == 8'h4D) ||
                     (a >= 8'h50 && a <= 8'h5F) || (a >= 8'h64 && a <= 8'h68) ||
                     (a >= 8'h6C && a <= 8'h6F) || (a >= 8'h71 && a <= 8'h75) ||
                     (a >= 8'h7A && a <= 8'h7F) || (a == 8'h81) ||
                     (a >= 8'h83 && a <= 8'h9F) || (a == 8'hA1) || (a == 8'hA9) ||
                     (a == 8'hAD) || (a >= 8'hAF);
                if (a >= 8'h60 && a <= 8'h63) begin
                    v = d & 8'h8F;
                end else begin
                    case (a)
                        8'h04: v = (d & 8'h08) | 8'h07;
                        8'h05: v = d & 8'h01;
                        8'h07: v = (old & ~(d & 8'h78)) | 8'h02;
                        8'h4F: v = d & 8'h01;
                        8'h6A: v = d & 8'hD7;
                        8'h80: v = d & 8'h80;
                        default: v = d;
                    endcase
                end
            end
            SLOT_IDE: begin
                ro = (a <= 8'h03) || (a >= 8'h08 && a <= 8'h0C) ||
                     (a >= 8'h0E && a <= 8'h1F) || (a >= 8'h24 && a <= 8'h3F) ||
                     (a >= 8'h45);
                v  = (a == 8'h20) ? (d | 8'h01) : d;
            end
            default: ro = 1'b1;
        endcase
        return ro ? old : v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pcicsa_ram.sv -----
// ----------------------------------------------------------------------------
// pcicsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcicsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/pci_config_space_access_unit.sv -----
// ----------------------------------------------------------------------------
// pci_config_space_access_unit
// Byte port accesses at CF8..CFF: address register, per-function config
// space with write rules, and ROM-region write permission map.
// ----------------------------------------------------------------------------
// Channel   Handshake                 Payload
// input     i_in_valid / o_in_stall   i_opcode, i_port_offset, i_write_data, i_rom_offset
// output    o_out_valid / i_out_stall o_read_data, o_write_allowed
//
// Address port accesses, ROM checks and unclaimed data cycles are answered
// in the cycle after acceptance. A claimed data cycle does a config RAM read,
// then, for a write, a modify and write. After reset the config RAM is loaded
// with defaults; no item is accepted meanwhile. A stalled result holds in the
// output register; the next item is taken once that register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_config_space_access_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [2:0]  i_port_offset,
    input  wire logic [7:0]  i_write_data,
    input  wire logic [17:0] i_rom_offset,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_read_data,
    output logic             o_write_allowed
);

    localparam int AW = pcicsa_pkg::STORE_AW;

    pcicsa_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_init_idx, n_init_idx;
    logic [31:0]   r_addr, n_addr;
    logic [1:0]    r_rom_perm [pcicsa_pkg::ROM_REGIONS];
    logic [1:0]    n_rom_perm [pcicsa_pkg::ROM_REGIONS];
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_rd, n_rd;
    logic          r_wa, n_wa;
    logic          r_is_wr, n_is_wr;
    logic [1:0]    r_slot, n_slot;
    logic [7:0]    r_off, n_off;
    logic [7:0]    r_data, n_data;

    logic          accept;
    logic          out_free;
    logic [1:0]    slot;
    logic          slot_ok;
    logic [7:0]    off;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [7:0]    new_byte;
    logic [31:0]   merged;
    logic [2:0]    pair;

    pcicsa_ram #(
        .WIDTH(8),
        .DEPTH(pcicsa_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        slot    = pcicsa_pkg::SLOT_HOST;
        slot_ok = 1'b1;
        case (r_addr[15:8])
            pcicsa_pkg::DEVFN_HOST: slot = pcicsa_pkg::SLOT_HOST;
            pcicsa_pkg::DEVFN_ISA:  slot = pcicsa_pkg::SLOT_ISA;
            pcicsa_pkg::DEVFN_IDE:  slot = pcicsa_pkg::SLOT_IDE;
            default:                slot_ok = 1'b0;
        endcase
        off = {r_addr[7:2], i_port_offset[1:0]};
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != pcicsa_pkg::ST_IDLE) || !out_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign ram_raddr  = {slot, off};
    assign new_byte   = pcicsa_pkg::cfg_rule(r_slot, r_off, ram_rdata, r_data);
    assign pair       = 3'(r_off - pcicsa_pkg::OFF_ROM_FIRST);

    always_comb begin
        merged = r_addr;
        case (i_port_offset[1:0])
            2'd0:    merged[7:0]   = i_write_data;
            2'd1:    merged[15:8]  = i_write_data;
            2'd2:    merged[23:16] = i_write_data;
            default: merged[31:24] = i_write_data;
        endcase
        merged = merged & ~pcicsa_pkg::ADDR_RESERVED;
    end

    always_comb begin
        n_state     = r_state;
        n_init_idx  = r_init_idx;
        n_addr      = r_addr;
        n_rom_perm  = r_rom_perm;
        n_out_valid = r_out_valid && i_out_stall;
        n_rd        = r_rd;
        n_wa        = r_wa;
        n_is_wr     = r_is_wr;
        n_slot      = r_slot;
        n_off       = r_off;
        n_data      = r_data;
        ram_we      = 1'b0;
        ram_waddr   = {r_slot, r_off};
        ram_wdata   = new_byte;

        case (r_state)
            pcicsa_pkg::ST_INIT: begin
                ram_we     = 1'b1;
                ram_waddr  = r_init_idx;
                ram_wdata  = pcicsa_pkg::cfg_default(r_init_idx[AW-1:AW-2],
                                                     r_init_idx[AW-3:0]);
                n_init_idx = r_init_idx + 1'b1;
                if (r_init_idx == AW'(pcicsa_pkg::STORE_DEPTH - 1)) begin
                    n_state = pcicsa_pkg::ST_IDLE;
                end
            end
            pcicsa_pkg::ST_IDLE: begin
                if (accept) begin
                    n_rd  = 8'h00;
                    n_wa  = 1'b0;
                    n_is_wr = (i_opcode == pcicsa_pkg::OP_WRITE);
                    n_slot  = slot;
                    n_off   = off;
                    n_data  = i_write_data;
                    n_out_valid = 1'b1;
                    if (i_opcode == pcicsa_pkg::OP_READ || i_opcode == pcicsa_pkg::OP_WRITE) begin
                        if (!i_port_offset[2]) begin
                            if (i_opcode == pcicsa_pkg::OP_WRITE) begin
                                n_addr = merged;
                            end else begin
                                n_rd = 8'(r_addr >> {i_port_offset[1:0], 3'b000});
                            end
                        end else if (!r_addr[31] || r_addr[23:16] != 8'h00 || !slot_ok) begin
                            if (i_opcode == pcicsa_pkg::OP_READ) begin
                                n_rd = pcicsa_pkg::NO_RESPONSE;
                            end
                        end else begin
                            // claimed data cycle: wait for the RAM read
                            n_out_valid = 1'b0;
                            n_state     = pcicsa_pkg::ST_RMW;
                        end
                    end else if (i_opcode == pcicsa_pkg::OP_CHECK) begin
                        n_wa = r_rom_perm[i_rom_offset[17:14]][1];
                    end
                end
            end
            pcicsa_pkg::ST_RMW: begin
                n_out_valid = 1'b1;
                n_state     = pcicsa_pkg::ST_IDLE;
                if (r_is_wr) begin
                    n_rd   = 8'h00;
                    ram_we = 1'b1;
                    if (r_slot == pcicsa_pkg::SLOT_HOST) begin
                        if (r_off == pcicsa_pkg::OFF_ROM_TOP) begin
                            for (int i = 12; i < pcicsa_pkg::ROM_REGIONS; i++) begin
                                n_rom_perm[i] = r_data[5:4];
                            end
                        end else if (r_off >= pcicsa_pkg::OFF_ROM_FIRST &&
                                     r_off <= pcicsa_pkg::OFF_ROM_LAST) begin
                            n_rom_perm[{pair, 1'b0}] = r_data[1:0];
                            n_rom_perm[{pair, 1'b1}] = r_data[5:4];
                        end
                    end
                end else begin
                    n_rd = ram_rdata;
                end
            end
            default: n_state = pcicsa_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcicsa_pkg::ST_INIT;
            r_init_idx  <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < pcicsa_pkg::ROM_REGIONS; i++) begin
                r_rom_perm[i] <= 2'b00;
            end
        end else begin
            r_state     <= n_state;
            r_init_idx  <= n_init_idx;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
            r_rom_perm  <= n_rom_perm;
        end
        r_rd    <= n_rd;
        r_wa    <= n_wa;
        r_is_wr <= n_is_wr;
        r_slot  <= n_slot;
        r_off   <= n_off;
        r_data  <= n_data;
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_rd;
    assign o_write_allowed = r_wa;

endmodule

`default_nettype wire

// ----- rtl/pcicsa_checker.sv -----
// ----------------------------------------------------------------------------
// pcicsa_checker
// Port-level checks for the configuration access unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module pcicsa_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_read_data,
    input wire logic       o_write_allowed
);

    // a check result never carries read data
    a_check_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_write_allowed |-> o_read_data == 8'h00)
        else $error("write_allowed with nonzero read_data");

    // an accepted item either answers next cycle or holds the input stalled
    a_item_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid || o_in_stall)
        else $error("accepted item neither answered nor in progress");

    // a pending result blocks new items while the output is stalled
    a_pending_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("item accepted while result stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_data))
        else $error("stalled result changed");

endmodule

bind pci_config_space_access_unit pcicsa_checker u_pcicsa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_read_data    (o_read_data),
    .o_write_allowed(o_write_allowed)
);

`default_nettype wire
